[rtl/pct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_pkg
// Shared widths, codes and defaults for the perceptron classify/train unit.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int FEATURES_DEF   = 8;   // default weight vector depth
  localparam int INPUT_FEATURES = 8;   // feature fields carried per request
  localparam int WEIGHT_W       = 32;
  localparam int FEAT_W         = 16;
  localparam int LABEL_W        = 2;
  localparam int PRED_W         = 2;
  localparam int PROD_W         = WEIGHT_W + FEAT_W;
  localparam int ACTIVE_W       = 4;

  localparam int IN_DATA_W      = ((INPUT_FEATURES * FEAT_W + LABEL_W + 7) / 8) * 8;
  localparam int LABEL_LSB      = INPUT_FEATURES * FEAT_W;
  localparam int OUT_DATA_W     = 8;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd8;

  // prediction codes
  localparam logic [PRED_W-1:0] PRED_POS  = 2'b01;
  localparam logic [PRED_W-1:0] PRED_NEG  = 2'b11;
  localparam logic [PRED_W-1:0] PRED_ZERO = 2'b00;

endpackage

[rtl/pct_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_mac
// Shared multiply-accumulate unit: one weight times one feature per cycle,
// product registered, then added into a wide exact accumulator.
// ----------------------------------------------------------------------------
module pct_mac #(
  parameter int ACC_W = pct_pkg::PROD_W + 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  logic                                en,
  input  logic signed [pct_pkg::WEIGHT_W-1:0] wgt,
  input  logic signed [pct_pkg::FEAT_W-1:0]   feat,
  output logic signed [ACC_W-1:0]             acc
);

  logic signed [pct_pkg::PROD_W-1:0] prod_r;
  logic                              vld_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           prod_ext;

  assign prod_ext = {{(ACC_W - pct_pkg::PROD_W){prod_r[pct_pkg::PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    prod_r <= wgt * feat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      acc_r <= '0;
    end else begin
      vld_r <= en;
      if (clr) begin
        acc_r <= '0;
      end else if (vld_r) begin
        acc_r <= acc_r + prod_ext;
      end
    end
  end

  assign acc = acc_r;

endmodule

[rtl/pct_upd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_upd
// Weight update step: adds label times feature to one weight and saturates
// the sum to the signed 32-bit range.
// ----------------------------------------------------------------------------
module pct_upd (
  input  logic signed [pct_pkg::WEIGHT_W-1:0] wgt,
  input  logic signed [pct_pkg::FEAT_W-1:0]   feat,
  input  logic signed [pct_pkg::LABEL_W-1:0]  label,
  output logic signed [pct_pkg::WEIGHT_W-1:0] wgt_new
);

  localparam int LF_W  = pct_pkg::FEAT_W + pct_pkg::LABEL_W;
  localparam int SUM_W = pct_pkg::WEIGHT_W + 1;

  logic signed [LF_W-1:0]  lf;
  logic signed [SUM_W-1:0] sum;

  assign lf  = label * feat;
  assign sum = {wgt[pct_pkg::WEIGHT_W-1], wgt}
             + {{(SUM_W - LF_W){lf[LF_W-1]}}, lf};

  always_comb begin
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      // overflow: clamp toward the sign of the true sum
      wgt_new = sum[SUM_W-1] ? {1'b1, {(pct_pkg::WEIGHT_W-1){1'b0}}}
                             : {1'b0, {(pct_pkg::WEIGHT_W-1){1'b1}}};
    end else begin
      wgt_new = sum[pct_pkg::WEIGHT_W-1:0];
    end
  end

endmodule

[rtl/perceptron_classify_train_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perceptron_classify_train_unit
// Online perceptron: classifies feature vectors and trains its weights.
// ----------------------------------------------------------------------------
// Usage: a request enters on in_* (features and label in in_tdata, mode in
// in_tuser) and gives exactly one result on out_* (prediction and change flag).
// n is the active count: cfg active_dims limited to FEATURES and to eight.
// The dot product runs on one shared multiply-accumulate unit, one weight per
// cycle. After acceptance the unit steps through MAC over the n weights,
// DRAIN and SIGN, then UPD (one update step per weight) when training
// updates the weights, and last OUT, where out_tvalid is high. At n = 0
// only SIGN and OUT run. in_tready is high only in idle; one request is in
// flight at a time and the next can be accepted the cycle after the result
// is taken.
// The result is held in an output register while out_tready is low; the unit
// waits and accepts no request until it is taken.
// Reset (rst_n low, synchronous) clears all weights to zero and sets
// active_dims to eight. cfg_we writes active_dims; write it only when idle.
// ----------------------------------------------------------------------------
module perceptron_classify_train_unit #(
  parameter int FEATURES = pct_pkg::FEATURES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // feature_0 .. feature_7 (16 bits each), label (2), zero pad
  input  logic [pct_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // prediction (2), weights_changed (1), zero pad
  output logic [pct_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic [pct_pkg::ACTIVE_W-1:0]       cfg_wdata
);

  localparam int NDIM   = (FEATURES < pct_pkg::INPUT_FEATURES) ? FEATURES
                                                              : pct_pkg::INPUT_FEATURES;
  localparam int IDX_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int ACC_W  = pct_pkg::PROD_W + $clog2(FEATURES) + 1;
  localparam int WW     = pct_pkg::WEIGHT_W;
  localparam int FW     = pct_pkg::FEAT_W;
  localparam int AW     = pct_pkg::ACTIVE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                         state_r, state_nxt;
  logic [IDX_W-1:0]                   cnt_r, cnt_nxt;
  logic [AW-1:0]                      active_dims_r;
  logic [AW-1:0]                      n_r;
  logic [AW-1:0]                      n_lim;
  logic                               mode_r;
  logic signed [pct_pkg::LABEL_W-1:0] label_r;
  logic [pct_pkg::PRED_W-1:0]         pred_r, pred_nxt;
  logic                               chg_r, chg_nxt;
  logic signed [WW-1:0]               weights_r [FEATURES];
  logic signed [FW-1:0]               feat_r [FEATURES];
  logic signed [ACC_W-1:0]            acc;
  logic signed [WW-1:0]               wgt_new;
  logic                               accept;
  logic                               last;
  logic                               mac_en;
  logic                               upd_en;
  logic [pct_pkg::PRED_W-1:0]         pred_sign;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign last      = (AW'(cnt_r) == (n_r - AW'(1)));
  assign mac_en    = (state_r == S_MAC);
  assign upd_en    = (state_r == S_UPD);
  assign n_lim     = (active_dims_r > AW'(NDIM)) ? AW'(NDIM) : active_dims_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dims_r <= pct_pkg::ACTIVE_RST;
    end else if (cfg_we) begin
      active_dims_r <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_tuser;
      label_r <= in_tdata[pct_pkg::LABEL_LSB +: pct_pkg::LABEL_W];
      n_r     <= n_lim;
    end
  end

  for (genvar g = 0; g < FEATURES; g++) begin : g_feat
    if (g < pct_pkg::INPUT_FEATURES) begin : g_load
      always_ff @(posedge clk) begin
        if (accept) begin
          feat_r[g] <= in_tdata[g*FW +: FW];
        end
      end
    end else begin : g_zero
      always_ff @(posedge clk) begin
        feat_r[g] <= '0;
      end
    end
  end

  pct_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (accept),
    .en    (mac_en),
    .wgt   (weights_r[cnt_r]),
    .feat  (feat_r[cnt_r]),
    .acc   (acc)
  );

  pct_upd u_upd (
    .wgt     (weights_r[cnt_r]),
    .feat    (feat_r[cnt_r]),
    .label   (label_r),
    .wgt_new (wgt_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FEATURES; i++) begin
        weights_r[i] <= '0;
      end
    end else if (upd_en) begin
      weights_r[cnt_r] <= wgt_new;
    end
  end

  always_comb begin
    if (acc == '0) begin
      pred_sign = pct_pkg::PRED_ZERO;
    end else if (acc[ACC_W-1]) begin
      pred_sign = pct_pkg::PRED_NEG;
    end else begin
      pred_sign = pct_pkg::PRED_POS;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pred_nxt  = pred_r;
    chg_nxt   = chg_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = (n_lim == '0) ? S_SIGN : S_MAC;
        end
      end
      S_MAC: begin
        if (last) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_SIGN;
      end
      S_SIGN: begin
        pred_nxt = pred_sign;
        cnt_nxt  = '0;
        // label pattern 10 never matches any prediction code
        chg_nxt  = mode_r && (pred_sign != label_r);
        if (mode_r && (pred_sign != label_r) && (n_r != '0)) begin
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_UPD: begin
        if (last) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pred_r <= pred_nxt;
    chg_r  <= chg_nxt;
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {{(pct_pkg::OUT_DATA_W - pct_pkg::PRED_W - 1){1'b0}}, chg_r, pred_r};

endmodule

[sim/tb_perceptron_classify_train_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perceptron_classify_train_unit
// Self-checking bench for the perceptron classify/train unit. A directed table
// covers reset state, extreme features, every label code and the active
// count edges. Random phases at several active counts follow, then a train
// run with label minus two on extreme features that walks two weights apart.
// Each result is checked against a fixed entry or shadow weights in the bench.
// ----------------------------------------------------------------------------
module tb_perceptron_classify_train_unit;
  import pct_pkg::*;

  localparam logic MODE_CLASSIFY = 1'b0;
  localparam logic MODE_TRAIN    = 1'b1;

  localparam logic [LABEL_W-1:0] LABEL_POS  = 2'b01;
  localparam logic [LABEL_W-1:0] LABEL_NEG  = 2'b11;
  localparam logic [LABEL_W-1:0] LABEL_ZERO = 2'b00;
  localparam logic [LABEL_W-1:0] LABEL_NEG2 = 2'b10;

  localparam longint WEIGHT_HI      = 64'sh7fff_ffff;
  localparam longint WEIGHT_LO      = -64'sh8000_0000;
  localparam int     SETTLE_CYCLES  = 24;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     ROWS           = 21;
  localparam int     SAT_REQUESTS   = 120;

  typedef logic [INPUT_FEATURES-1:0][FEAT_W-1:0] feat_vec_t;

  typedef struct packed {
    logic [PRED_W-1:0] pred;
    logic              chg;
  } verdict_t;

  typedef struct {
    logic                do_cfg;
    logic [ACTIVE_W-1:0] dims;
    logic                mode;
    feat_vec_t           feats;
    logic [LABEL_W-1:0]  label;
    logic                fixed;
    logic [PRED_W-1:0]   pred;
    logic                chg;
  } vector_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [ACTIVE_W-1:0]   cfg_wdata  = '0;

  // shadow state of the unit
  int                  weight_vec [FEATURES_DEF];
  logic [ACTIVE_W-1:0] dims_reg;
  verdict_t            pending_verdicts [$];

  int          errors      = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  bit          tx_free     = 1'b0;
  bit          rx_free     = 1'b0;
  logic [15:0] ready_pattern = 16'hffff;
  int          pattern_age = 0;
  verdict_t    head;
  vector_row_t directed_rows [ROWS];

  always #6 clk = ~clk;

  perceptron_classify_train_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // sign of the dot product, then the perceptron update on a training miss
  task automatic score_and_learn(input logic m, input feat_vec_t f,
                                 input logic [LABEL_W-1:0] lab, output verdict_t v);
    longint acc;
    longint sum;
    longint lab_v;
    longint sign_v;
    int     n;
    n = (dims_reg > FEATURES_DEF) ? FEATURES_DEF : int'(dims_reg);
    acc = 0;
    for (int i = 0; i < n; i++) acc += longint'(weight_vec[i]) * longint'(signed'(f[i]));
    sign_v = (acc > 0) ? 1 : ((acc < 0) ? -1 : 0);
    v.pred = (acc > 0) ? PRED_POS : ((acc < 0) ? PRED_NEG : PRED_ZERO);
    v.chg  = 1'b0;
    lab_v  = longint'(signed'(lab));
    if (m == MODE_TRAIN && sign_v != lab_v) begin
      for (int i = 0; i < n; i++) begin
        sum = longint'(weight_vec[i]) + lab_v * longint'(signed'(f[i]));
        if (sum > WEIGHT_HI) sum = WEIGHT_HI;
        if (sum < WEIGHT_LO) sum = WEIGHT_LO;
        weight_vec[i] = int'(sum);
      end
      v.chg = 1'b1;
    end
  endtask

  task automatic pace_sender();
    int gap;
    gap = 0;
    if (!tx_free) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 10);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_request(input logic m, input feat_vec_t f, input logic [LABEL_W-1:0] lab,
                              input logic fixed, input logic [PRED_W-1:0] fpred,
                              input logic fchg);
    verdict_t v;
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {{(IN_DATA_W - LABEL_LSB - LABEL_W){1'b0}}, lab, f};
    do @(posedge clk); while (!in_tready);
    score_and_learn(m, f, lab, v);
    if (fixed) begin
      v.pred = fpred;
      v.chg  = fchg;
    end
    pending_verdicts = {pending_verdicts, v};
    pace_sender();
  endtask

  // sender pause: every request answered and the unit back in idle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(input logic [ACTIVE_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dims_reg  = d;
  endtask

  function automatic logic [FEAT_W-1:0] rand_feature();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($urandom_range(0, 512) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_request();
    feat_vec_t          f;
    logic [LABEL_W-1:0] lab;
    logic               m;
    for (int i = 0; i < INPUT_FEATURES; i++) f[i] = rand_feature();
    m = ($urandom_range(0, 9) < 6) ? MODE_TRAIN : MODE_CLASSIFY;
    if ($urandom_range(0, 1)) begin
      // separable target so training settles and matches show up
      lab = ($signed(f[0]) + $signed(f[1]) - $signed(f[2]) >= 0) ? LABEL_POS : LABEL_NEG;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: lab = LABEL_POS;
        4, 5, 6, 7: lab = LABEL_NEG;
        8:          lab = LABEL_ZERO;
        default:    lab = LABEL_NEG2;
      endcase
    end
    send_request(m, f, lab, 1'b0, PRED_ZERO, 1'b0);
  endtask

  function automatic vector_row_t mk_row(input logic cfg_on, input logic [ACTIVE_W-1:0] d,
                                         input logic m, input feat_vec_t f,
                                         input logic [LABEL_W-1:0] lab, input logic fx,
                                         input logic [PRED_W-1:0] ep, input logic ec);
    vector_row_t r;
    r.do_cfg = cfg_on;
    r.dims   = d;
    r.mode   = m;
    r.feats  = f;
    r.label  = lab;
    r.fixed  = fx;
    r.pred   = ep;
    r.chg    = ec;
    return r;
  endfunction

  // receiver stalls on a rotating pattern, reloaded when pattern_age wraps
  always @(posedge clk) begin
    if (rx_free) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ready_pattern[0];
    end
    if (pattern_age == 63) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 16'($urandom);
        1:       ready_pattern <= 16'hffff;
        default: ready_pattern <= 16'($urandom) | 16'($urandom);
      endcase
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    pattern_age <= (pattern_age + 1) % 64;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with no request pending, got %h", $time, out_tdata);
        errors++;
      end else begin
        head = pending_verdicts.pop_front();
        if (out_tdata[1:0] !== head.pred) begin
          $display("%0t: prediction expected %b got %b", $time, head.pred, out_tdata[1:0]);
          errors++;
        end
        if (out_tdata[2] !== head.chg) begin
          $display("%0t: weights_changed expected %b got %b", $time, head.chg, out_tdata[2]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int        phase;
    int        k;
    int        dims_plan [6];
    feat_vec_t f;
    dims_plan = '{8, 1, 15, 0, 4, 8};
    for (int i = 0; i < FEATURES_DEF; i++) weight_vec[i] = 0;
    dims_reg = ACTIVE_RST;

    directed_rows[0]  = mk_row(0, 0, MODE_CLASSIFY, {8{16'h7fff}}, LABEL_ZERO, 1, PRED_ZERO, 0);
    directed_rows[1]  = mk_row(0, 0, MODE_TRAIN, {8{16'h8000}}, LABEL_ZERO, 1, PRED_ZERO, 0);
    directed_rows[2]  = mk_row(0, 0, MODE_TRAIN, {8{16'h7fff}}, LABEL_POS, 1, PRED_ZERO, 1);
    directed_rows[3]  = mk_row(0, 0, MODE_CLASSIFY, {8{16'h7fff}}, LABEL_ZERO, 1, PRED_POS, 0);
    directed_rows[4]  = mk_row(0, 0, MODE_CLASSIFY, {8{16'h8000}}, LABEL_ZERO, 1, PRED_NEG, 0);
    directed_rows[5]  = mk_row(0, 0, MODE_TRAIN, {8{16'h7fff}}, LABEL_POS, 1, PRED_POS, 0);
    // zero label still counts as a miss, weights stay put
    directed_rows[6]  = mk_row(0, 0, MODE_TRAIN, {8{16'h0100}}, LABEL_ZERO, 1, PRED_POS, 1);
    directed_rows[7]  = mk_row(0, 0, MODE_TRAIN, {8{16'h0001}}, LABEL_NEG2, 1, PRED_POS, 1);
    directed_rows[8]  = mk_row(0, 0, MODE_TRAIN,
                               {16'h7fff, 16'h8000, 16'h0001, 16'hffff,
                                16'h0100, 16'hff00, 16'h1234, 16'hedcc},
                               LABEL_NEG, 0, PRED_ZERO, 0);
    // no active positions: always zero, a train miss still flags
    directed_rows[9]  = mk_row(1, 0, MODE_CLASSIFY, {8{16'h7fff}}, LABEL_ZERO, 1, PRED_ZERO, 0);
    directed_rows[10] = mk_row(0, 0, MODE_TRAIN, {8{16'h7fff}}, LABEL_POS, 1, PRED_ZERO, 1);
    directed_rows[11] = mk_row(1, 15, MODE_CLASSIFY, {8{16'h7fff}}, LABEL_ZERO, 0, PRED_ZERO, 0);
    directed_rows[12] = mk_row(1, 1, MODE_TRAIN, {{7{16'h7fff}}, 16'h8000}, LABEL_POS,
                               0, PRED_ZERO, 0);
    directed_rows[13] = mk_row(0, 0, MODE_CLASSIFY, {{7{16'h7fff}}, 16'h0000}, LABEL_ZERO,
                               1, PRED_ZERO, 0);
    directed_rows[14] = mk_row(1, 8, MODE_TRAIN, {4{16'h5555, 16'haaaa}}, LABEL_NEG,
                               0, PRED_ZERO, 0);
    directed_rows[15] = mk_row(0, 0, MODE_CLASSIFY, {8{16'hffff}}, LABEL_ZERO, 0, PRED_ZERO, 0);
    directed_rows[16] = mk_row(0, 0, MODE_TRAIN, {8{16'h8000}}, LABEL_NEG2, 0, PRED_ZERO, 0);
    directed_rows[17] = mk_row(0, 0, MODE_CLASSIFY,
                               {16'h1234, 16'h8765, 16'h00ff, 16'hff01,
                                16'h4000, 16'hc000, 16'h7ffe, 16'h8001},
                               LABEL_ZERO, 0, PRED_ZERO, 0);
    directed_rows[18] = mk_row(0, 0, MODE_TRAIN, {8{16'h0000}}, LABEL_POS, 1, PRED_ZERO, 1);
    directed_rows[19] = mk_row(1, 3, MODE_TRAIN,
                               {16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h2000, 16'he000, 16'h3000},
                               LABEL_NEG, 0, PRED_ZERO, 0);
    directed_rows[20] = mk_row(0, 0, MODE_CLASSIFY, {8{16'h0200}}, LABEL_POS, 0, PRED_ZERO, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].do_cfg) begin
        quiesce();
        write_dims(directed_rows[r].dims);
      end
      send_request(directed_rows[r].mode, directed_rows[r].feats, directed_rows[r].label,
                   directed_rows[r].fixed, directed_rows[r].pred, directed_rows[r].chg);
    end

    for (phase = 0; phase < 6; phase++) begin
      quiesce();
      write_dims((phase < 5) ? 4'(dims_plan[phase]) : 4'($urandom_range(0, 15)));
      tx_free = (phase == 2);
      rx_free = (phase == 2);
      for (k = 0; k < 160; k++) random_request();
    end

    // label -2 on min/max features walks w0 up and w1 down toward their limits
    quiesce();
    write_dims(4'd2);
    tx_free = 1'b1;
    rx_free = 1'b1;
    for (k = 0; k < SAT_REQUESTS; k++) begin
      for (int i = 0; i < INPUT_FEATURES; i++) f[i] = 16'($urandom);
      f[0] = 16'h8000;
      f[1] = 16'h7fff;
      send_request(MODE_TRAIN, f, LABEL_NEG2, 1'b0, PRED_ZERO, 1'b0);
    end

    quiesce();
    write_dims(4'd8);
    tx_free = 1'b0;
    rx_free = 1'b0;
    for (k = 0; k < 100; k++) random_request();

    quiesce();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pct_pkg.sv
rtl/pct_mac.sv
rtl/pct_upd.sv
rtl/perceptron_classify_train_unit.sv
sim/tb_perceptron_classify_train_unit.sv
